[design/cte_pkg.sv]
// Shared types, codes and defaults for the cursor text buffer.
package cte_pkg;

  localparam int CAP_DEFAULT = 1024;
  localparam int CHAR_W      = 8;
  localparam int POS_W       = 10;
  localparam int COUNT_OUT_W = 11;

  // command kinds
  localparam logic [2:0] KIND_LEFT   = 3'd0;
  localparam logic [2:0] KIND_RIGHT  = 3'd1;
  localparam logic [2:0] KIND_BACK   = 3'd2;
  localparam logic [2:0] KIND_INSERT = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  // result status
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_RANGE   = 2'd2;
  localparam logic [1:0] STAT_UNKNOWN = 2'd3;

  // count updates applied when a command retires
  localparam logic [2:0] CNT_HOLD  = 3'd0;
  localparam logic [2:0] CNT_LEFT  = 3'd1;
  localparam logic [2:0] CNT_RIGHT = 3'd2;
  localparam logic [2:0] CNT_BACK  = 3'd3;
  localparam logic [2:0] CNT_INS   = 3'd4;

  typedef struct packed {
    logic [2:0]        kind;
    logic [CHAR_W-1:0] insert_char;
    logic [POS_W-1:0]  read_position;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0]      read_char;
    logic [COUNT_OUT_W-1:0] text_length;
    logic [COUNT_OUT_W-1:0] cursor_index;
    logic [1:0]             status;
  } out_t;

  // per-command plan from the decoder to the sequencer
  typedef struct packed {
    logic       rd_en;
    logic       wr_en;
    logic       wr_char;
    logic       ret_char;
    logic [2:0] cnt_op;
    logic [1:0] status;
  } plan_t;

endpackage

[design/cte_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module cte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/cte_decode.sv]
// Command decoder: gap-buffer addresses, count update and status for one command.
module cte_decode import cte_pkg::*; #(
  parameter int CAPACITY = CAP_DEFAULT,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  in_t           cmd,
  input  logic [CW-1:0] left_count,
  input  logic [CW-1:0] right_count,
  output plan_t         plan,
  output logic [AW-1:0] rd_addr,
  output logic [AW-1:0] wr_addr
);

  localparam int TW = CW + 1;
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [TW-1:0] total;
  logic [CW-1:0] right_base;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] left_x;
  logic [XW-1:0] right_x;
  logic [XW-1:0] offset;

  assign total      = TW'(left_count) + TW'(right_count);
  assign right_base = CW'(CAPACITY) - right_count;
  assign pos_x      = XW'(cmd.read_position);
  assign left_x     = XW'(left_count);
  assign right_x    = XW'(right_count);
  assign offset     = pos_x - left_x;

  always_comb begin
    plan    = '0;
    rd_addr = '0;
    wr_addr = AW'(left_count);
    case (cmd.kind)
      KIND_LEFT: begin
        if (left_count != '0) begin
          plan.rd_en  = 1'b1;
          plan.wr_en  = 1'b1;
          plan.cnt_op = CNT_LEFT;
          rd_addr     = AW'(left_count - CW'(1));
          wr_addr     = AW'(right_base - CW'(1));
        end
      end
      KIND_RIGHT: begin
        if (right_count != '0) begin
          plan.rd_en  = 1'b1;
          plan.wr_en  = 1'b1;
          plan.cnt_op = CNT_RIGHT;
          rd_addr     = AW'(right_base);
        end
      end
      KIND_BACK: begin
        if (left_count != '0) begin
          plan.cnt_op = CNT_BACK;
        end
      end
      KIND_INSERT: begin
        if (total >= TW'(CAPACITY)) begin
          plan.status = STAT_FULL;
        end else begin
          plan.wr_en   = 1'b1;
          plan.wr_char = 1'b1;
          plan.cnt_op  = CNT_INS;
        end
      end
      KIND_READ: begin
        if (pos_x < left_x) begin
          plan.rd_en    = 1'b1;
          plan.ret_char = 1'b1;
          rd_addr       = AW'(pos_x);
        end else if (offset < right_x) begin
          plan.rd_en    = 1'b1;
          plan.ret_char = 1'b1;
          rd_addr       = AW'(XW'(right_base) + offset);
        end else begin
          plan.status = STAT_RANGE;
        end
      end
      default: begin
        plan.status = STAT_UNKNOWN;
      end
    endcase
  end

endmodule

[design/cursor_text_buffer.sv]
// Top level of the cursor text buffer: sequencer, cursor counts and result register.
//
// A line-editor text buffer kept as a gap buffer in one RAM of CAPACITY bytes.
// Input channel (in_valid, in_stall, in_data): one command per transfer, kinds
// left, right, backspace, insert and read; other kinds return an unknown status.
// Result channel (out_valid, out_stall, out_data): exactly one result per command,
// in command order, carrying the read character, text length, cursor index and
// status after the command.
// A command is accepted in S_IDLE, which issues the RAM read; in S_FIN the block
// uses the read data, writes the moved or inserted character back and
// updates the counts. Because of this one-read-then-write RAM round trip, a new
// command is accepted only after the last one leaves S_FIN. out_valid is
// registered and rises as the command leaves S_FIN.
// While out_stall holds a result, the command behind it waits in S_FIN
// and in_stall stays high; nothing is lost.
// Reset (rst_n low, synchronous) empties the text and puts the cursor at 0;
// the RAM is not cleared, since no command reads outside the held text.
module cursor_text_buffer import cte_pkg::*; #(
  parameter int CAPACITY = CAP_DEFAULT
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_FIN  = 1'b1;

  logic              state_r, state_nxt;
  logic [CW-1:0]     left_r, left_nxt;
  logic [CW-1:0]     right_r, right_nxt;
  plan_t             plan, plan_r;
  logic [AW-1:0]     rd_addr, wr_addr, wr_addr_r;
  logic [CHAR_W-1:0] char_r;
  logic [CHAR_W-1:0] rd_data;
  logic [CHAR_W-1:0] wr_data;
  logic              in_fire, fin_fire;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  cte_decode #(.CAPACITY(CAPACITY)) u_decode (
    .cmd         (in_data),
    .left_count  (left_r),
    .right_count (right_r),
    .plan        (plan),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign fin_fire = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  assign wr_data  = plan_r.wr_char ? char_r : rd_data;

  cte_ram #(.WIDTH(CHAR_W), .DEPTH(CAPACITY)) u_store (
    .clk     (clk),
    .wr_en   (fin_fire && plan_r.wr_en),
    .wr_addr (wr_addr_r),
    .wr_data (wr_data),
    .rd_en   (in_fire && plan.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    left_nxt  = left_r;
    right_nxt = right_r;
    case (plan_r.cnt_op)
      CNT_LEFT: begin
        left_nxt  = left_r - CW'(1);
        right_nxt = right_r + CW'(1);
      end
      CNT_RIGHT: begin
        left_nxt  = left_r + CW'(1);
        right_nxt = right_r - CW'(1);
      end
      CNT_BACK: left_nxt = left_r - CW'(1);
      CNT_INS:  left_nxt = left_r + CW'(1);
      default:  ;
    endcase
  end

  always_comb begin
    out_data_nxt.read_char    = plan_r.ret_char ? rd_data : '0;
    out_data_nxt.text_length  = COUNT_OUT_W'((CW + 1)'(left_nxt) + (CW + 1)'(right_nxt));
    out_data_nxt.cursor_index = COUNT_OUT_W'(left_nxt);
    out_data_nxt.status       = plan_r.status;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_FIN;
      S_FIN:   if (fin_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      left_r      <= '0;
      right_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fin_fire) begin
        left_r  <= left_nxt;
        right_r <= right_nxt;
      end
    end
  end

  // hold the command's plan, write address and character through S_FIN
  always_ff @(posedge clk) begin
    if (in_fire) begin
      plan_r    <= plan;
      wr_addr_r <= wr_addr;
      char_r    <= in_data.insert_char;
    end
    if (fin_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/cte_checker.sv]
// Port-level checks on the cursor text buffer, bound to the top level.
module cte_checker import cte_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // a result held back by the receiver stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // one command in flight: no transfer in the cycle after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("command accepted back to back");

  a_cursor_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.cursor_index <= out_data.text_length)
    else $error("cursor beyond end of text");

  a_char_only_when_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STAT_OK |-> out_data.read_char == '0)
    else $error("character returned with error status");

endmodule

bind cursor_text_buffer cte_checker u_cte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[dv/tb_cursor_text_buffer.sv]
// Self-checking testbench for the gap-buffer line editor: edge cases, random edits, full buffer.
module tb_cursor_text_buffer import cte_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TB_CAP = CAP_DEFAULT;
  localparam int IDLE_LIMIT = 5000;
  localparam int RANDOM_EDITS = 40;
  localparam logic [2:0] KIND_UNUSED_LO  = 3'd5;
  localparam logic [2:0] KIND_UNUSED_MID = 3'd6;
  localparam logic [2:0] KIND_UNUSED_HI  = 3'd7;

  // Shadow of the editor: its own gap buffer plus the results still owed by the block.
  class edit_tracker;
    logic [CHAR_W-1:0] chars [TB_CAP];
    int left_cnt;
    int right_cnt;
    out_t owed_q[$];
    int mismatches;

    function new();
      left_cnt = 0;
      right_cnt = 0;
      mismatches = 0;
    endfunction

    function int text_len();
      return left_cnt + right_cnt;
    endfunction

    function int owed();
      return owed_q.size();
    endfunction

    // Apply one accepted command and queue the result it must produce.
    function void note_command(in_t cmd);
      out_t res;
      int base;
      int pos;
      res = '0;
      res.status = STAT_OK;
      base = TB_CAP - right_cnt;
      pos = int'(cmd.read_position);
      case (cmd.kind)
        KIND_LEFT: begin
          if (left_cnt > 0) begin
            chars[base - 1] = chars[left_cnt - 1];
            left_cnt--;
            right_cnt++;
          end
        end
        KIND_RIGHT: begin
          if (right_cnt > 0) begin
            chars[left_cnt] = chars[base];
            left_cnt++;
            right_cnt--;
          end
        end
        KIND_BACK: begin
          if (left_cnt > 0) left_cnt--;
        end
        KIND_INSERT: begin
          if (left_cnt + right_cnt >= TB_CAP) begin
            res.status = STAT_FULL;
          end else begin
            chars[left_cnt] = cmd.insert_char;
            left_cnt++;
          end
        end
        KIND_READ: begin
          if (pos < left_cnt) begin
            res.read_char = chars[pos];
          end else if (pos - left_cnt < right_cnt) begin
            res.read_char = chars[base + pos - left_cnt];
          end else begin
            res.status = STAT_RANGE;
          end
        end
        default: res.status = STAT_UNKNOWN;
      endcase
      res.text_length = COUNT_OUT_W'(left_cnt + right_cnt);
      res.cursor_index = COUNT_OUT_W'(left_cnt);
      owed_q = {owed_q, res};
    endfunction

    function void field_check(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
        mismatches++;
      end
    endfunction

    function void check_result(out_t got);
      out_t exp_res;
      if (owed_q.size() == 0) begin
        $error("unexpected result: read_char %0d text_length %0d cursor_index %0d status %0d",
               got.read_char, got.text_length, got.cursor_index, got.status);
        mismatches++;
        return;
      end
      exp_res = owed_q.pop_front();
      field_check("read_char", int'(exp_res.read_char), int'(got.read_char));
      field_check("text_length", int'(exp_res.text_length), int'(got.text_length));
      field_check("cursor_index", int'(exp_res.cursor_index), int'(got.cursor_index));
      field_check("status", int'(exp_res.status), int'(got.status));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  edit_tracker tracker;
  int burst_left;
  int stall_pct;
  int stall_seg;
  int idle_cycles;

  cursor_text_buffer #(.CAPACITY(TB_CAP)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_t make_cmd(logic [2:0] kind, logic [CHAR_W-1:0] ch,
                                   logic [POS_W-1:0] pos);
    in_t c;
    c.kind = kind;
    c.insert_char = ch;
    c.read_position = pos;
    return c;
  endfunction

  // Send one command; the sender runs in bursts with random gaps between them.
  task automatic issue(in_t cmd);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 2);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.note_command(cmd);
  endtask

  // Hold off the sender until every owed result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (tracker.owed() != 0) @(posedge clk);
  endtask

  // One random command; ins_pct sets how often it is an insert.
  task automatic random_edit(int ins_pct);
    in_t c;
    int r;
    c = make_cmd(KIND_LEFT, CHAR_W'($urandom), POS_W'($urandom));
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < ins_pct) begin
      c.kind = KIND_INSERT;
    end else if (r < 22) begin
      c.kind = KIND_LEFT;
    end else if (r < 44) begin
      c.kind = KIND_RIGHT;
    end else if (r < 62) begin
      c.kind = KIND_BACK;
    end else if (r < 92) begin
      c.kind = KIND_READ;
      if (tracker.text_len() > 0 && $urandom_range(0, 3) != 0)
        c.read_position = POS_W'($urandom_range(0, tracker.text_len() - 1));
    end else begin
      c.kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
    end
    issue(c);
  endtask

  // Receiver: stall probability changes from segment to segment, including zero.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_seg = 0;
    end else begin
      if (stall_seg == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
        stall_seg = $urandom_range(30, 300);
      end
      stall_seg--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    tracker = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    idle_cycles = 0;
    burst_left = 0;
    stall_pct = 0;
    stall_seg = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // edges of an empty buffer, unknown kinds, extreme characters
    issue(make_cmd(KIND_LEFT, 8'hFF, 10'h3FF));
    issue(make_cmd(KIND_RIGHT, 8'h00, 10'h000));
    issue(make_cmd(KIND_BACK, 8'hAA, 10'h155));
    issue(make_cmd(KIND_READ, 8'h55, 10'h000));
    issue(make_cmd(KIND_UNUSED_LO, 8'hFF, 10'h3FF));
    issue(make_cmd(KIND_UNUSED_MID, 8'h00, 10'h000));
    issue(make_cmd(KIND_UNUSED_HI, 8'h5A, 10'h2AA));
    issue(make_cmd(KIND_INSERT, 8'h00, 10'h3FF));
    issue(make_cmd(KIND_INSERT, 8'hFF, 10'h000));
    issue(make_cmd(KIND_INSERT, 8'h41, 10'h155));
    issue(make_cmd(KIND_LEFT, 8'h00, 10'h000));
    issue(make_cmd(KIND_LEFT, 8'h00, 10'h000));
    issue(make_cmd(KIND_INSERT, 8'h5A, 10'h000));
    issue(make_cmd(KIND_READ, 8'hFF, 10'd0));
    issue(make_cmd(KIND_READ, 8'h00, 10'd1));
    issue(make_cmd(KIND_READ, 8'h00, 10'd3));
    issue(make_cmd(KIND_READ, 8'h00, 10'd4));
    issue(make_cmd(KIND_READ, 8'h00, 10'h3FF));
    issue(make_cmd(KIND_RIGHT, 8'h00, 10'h000));
    issue(make_cmd(KIND_BACK, 8'h00, 10'h000));
    issue(make_cmd(KIND_RIGHT, 8'h00, 10'h000));
    issue(make_cmd(KIND_RIGHT, 8'h00, 10'h000));
    issue(make_cmd(KIND_READ, 8'h00, 10'd2));
    drain();

    for (int i = 0; i < RANDOM_EDITS; i++) begin
      random_edit(35);
      if (i == RANDOM_EDITS / 2) drain();
    end

    // fill the buffer, then hit it while full
    while (tracker.text_len() < TB_CAP)
      issue(make_cmd(KIND_INSERT, CHAR_W'($urandom), POS_W'($urandom)));
    repeat (4) issue(make_cmd(KIND_INSERT, CHAR_W'($urandom), POS_W'($urandom)));
    issue(make_cmd(KIND_READ, 8'h00, 10'h3FF));
    issue(make_cmd(KIND_READ, 8'h00, 10'h000));
    repeat (12) random_edit(50);
    while (tracker.right_cnt > 0) issue(make_cmd(KIND_RIGHT, 8'h00, 10'h000));
    issue(make_cmd(KIND_INSERT, 8'h7E, 10'h000));
    issue(make_cmd(KIND_READ, 8'h00, POS_W'(TB_CAP - 1)));
    repeat (12) issue(make_cmd(KIND_BACK, CHAR_W'($urandom), POS_W'($urandom)));
    repeat (8) random_edit(30);

    drain();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.owed() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[cursor_text_buffer.f]
design/cte_pkg.sv
design/cte_ram.sv
design/cte_decode.sv
design/cursor_text_buffer.sv
design/cte_checker.sv
dv/tb_cursor_text_buffer.sv
